>>> hw/rtl/cac_pkg.sv
`timescale 1ns / 1ps

package cac_pkg;

  localparam int unsigned MaxValueBound = 128;
  localparam int unsigned ElemW         = 8;
  localparam int unsigned CountW        = 30;
  localparam int unsigned IdxW          = $clog2(MaxValueBound);
  localparam int unsigned MaxW          = $clog2(MaxValueBound + 1);
  localparam int unsigned CmpW          = (MaxW > ElemW) ? MaxW : ElemW;
  localparam int unsigned CntW          = $clog2(MaxValueBound + 3);

  localparam logic [CountW-1:0] Modulus       = 30'd1000000007;
  localparam logic [ElemW-1:0]  MaxValueReset = 8'd100;

  // sweep control from the sequencer to the update cell
  typedef struct packed {
    logic            calc;
    logic            clr;
    logic            seed;
    logic [IdxW-1:0] idx;
    logic [CmpW-1:0] elem;
    logic [CmpW-1:0] mval;
  } ctl_t;

endpackage

>>> hw/rtl/cac_ram.sv
`timescale 1ns / 1ps

module cac_ram (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [cac_pkg::IdxW-1:0]            waddr_i,
  input  logic [cac_pkg::CountW-1:0]          wdata_i,
  input  logic                                re_i,
  input  logic [cac_pkg::IdxW-1:0]            raddr_i,
  output logic [cac_pkg::CountW-1:0]          rdata_o
);

  logic [cac_pkg::CountW-1:0] mem_q [cac_pkg::MaxValueBound];
  logic [cac_pkg::CountW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/cac_cell.sv
`timescale 1ns / 1ps

module cac_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  cac_pkg::ctl_t                       ctl_i,
  input  logic [cac_pkg::CountW-1:0]          rdata_i,
  output logic                                ram_we_o,
  output logic [cac_pkg::IdxW-1:0]            ram_waddr_o,
  output logic [cac_pkg::CountW-1:0]          ram_wdata_o,
  output logic [cac_pkg::CountW-1:0]          acc_o
);

  logic [cac_pkg::CountW-1:0] prev_q, cur_q;
  logic                       wr_valid_q;
  logic [cac_pkg::IdxW-1:0]   wr_addr_q;
  logic [cac_pkg::CountW-1:0] wr_data_q, wr_data_d;
  logic [cac_pkg::CountW-1:0] acc_q, acc_d;

  logic [cac_pkg::CmpW-1:0]   idx_ext, idx_p1;
  logic                       keep, has_prev, has_next;
  logic [cac_pkg::CountW-1:0] term_b, term_c;
  logic [cac_pkg::CountW+1:0] tot, red, mod1, mod2;
  logic [cac_pkg::CountW:0]   acc_sum;

  // sliding window over the old counts
  always_ff @(posedge clk_i) begin
    prev_q <= cur_q;
    cur_q  <= rdata_i;
  end

  always_comb begin
    idx_ext  = cac_pkg::CmpW'(ctl_i.idx);
    idx_p1   = idx_ext + cac_pkg::CmpW'(1);
    keep     = (idx_ext < ctl_i.mval) &&
               ((ctl_i.elem == '0) || (ctl_i.elem == idx_p1));
    has_prev = (ctl_i.idx != '0);
    has_next = (idx_p1 < ctl_i.mval);
    term_b   = has_prev ? prev_q : '0;
    term_c   = has_next ? rdata_i : '0;
    mod1     = {2'b00, cac_pkg::Modulus};
    mod2     = {1'b0, cac_pkg::Modulus, 1'b0};
    tot      = {2'b00, cur_q} + {2'b00, term_b} + {2'b00, term_c};
    if (tot >= mod2) begin
      red = tot - mod2;
    end else if (tot >= mod1) begin
      red = tot - mod1;
    end else begin
      red = tot;
    end
    if (!keep) begin
      wr_data_d = '0;
    end else if (ctl_i.seed) begin
      wr_data_d = cac_pkg::CountW'(1);
    end else begin
      wr_data_d = red[cac_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
    end else begin
      wr_valid_q <= ctl_i.calc;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= ctl_i.idx;
    wr_data_q <= wr_data_d;
  end

  // running sum of the new counts
  always_comb begin
    acc_sum = {1'b0, acc_q} + {1'b0, wr_data_q};
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (!wr_valid_q) begin
      acc_d = acc_q;
    end else if (acc_sum >= {1'b0, cac_pkg::Modulus}) begin
      acc_d = cac_pkg::CountW'(acc_sum - {1'b0, cac_pkg::Modulus});
    end else begin
      acc_d = acc_sum[cac_pkg::CountW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign ram_we_o    = wr_valid_q;
  assign ram_waddr_o = wr_addr_q;
  assign ram_wdata_o = wr_data_q;
  assign acc_o       = acc_q;

endmodule

>>> hw/rtl/constrained_array_count_dp.sv
`timescale 1ns / 1ps

// Counts arrays over 1..max_value whose neighbouring entries differ by at
// most one, modulo 1000000007, one array element per input transaction.
// Input channel: elem_value_i (0 = free, else fixed value) and is_last_i,
// taken on in_valid_i & in_ready_o. Output channel: count_o, one transaction
// for each element marked last, handed over on out_valid_o & out_ready_i.
// max_value is written through cfg_we_i / cfg_wdata_i and used capped at
// MaxValueBound; the user must write it only while idle, as the block itself
// does not enforce this. Each element costs one sweep over the count memory,
// its length set by the single read and single write port of that memory;
// a final state then returns to idle and, after a last element, hands the
// sum over.
// One element is in work at a time. A finished count waits in the output
// register while the next element is swept; only a second count that is
// ready before the first is taken holds the block in its final state.
// Reset (rst_ni low) sets max_value to 100, empties the output register and
// arms the block for the first element of a new array; the memory needs no
// clearing because every first element rewrites all entries.
module constrained_array_count_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [7:0]                          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [7:0]                          elem_value_i,
  input  logic                                is_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [29:0]                         count_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StSweep = 2'd1;
  localparam logic [1:0] StFin   = 2'd2;

  localparam logic [cac_pkg::CntW-1:0] CntRdEnd = cac_pkg::CntW'(cac_pkg::MaxValueBound);
  localparam logic [cac_pkg::CntW-1:0] CntCalcLo = cac_pkg::CntW'(2);
  localparam logic [cac_pkg::CntW-1:0] CntCalcHi = cac_pkg::CntW'(cac_pkg::MaxValueBound + 1);
  localparam logic [cac_pkg::CntW-1:0] CntEnd = cac_pkg::CntW'(cac_pkg::MaxValueBound + 2);

  logic [1:0]                   state_q, state_d;
  logic [cac_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [cac_pkg::ElemW-1:0]    max_value_q;
  logic                         first_q, first_d;
  logic [cac_pkg::ElemW-1:0]    elem_q;
  logic                         last_q;
  logic                         out_valid_q, out_valid_d;
  logic [cac_pkg::CountW-1:0]   count_q, count_d;

  logic                         accept;
  logic [cac_pkg::CmpW-1:0]     max_ext, mval;
  cac_pkg::ctl_t                ctl;
  logic                         ram_re, ram_we;
  logic [cac_pkg::IdxW-1:0]     ram_waddr;
  logic [cac_pkg::CountW-1:0]   ram_wdata, ram_rdata, acc;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    max_ext = cac_pkg::CmpW'(max_value_q);
    if (max_ext > cac_pkg::CmpW'(cac_pkg::MaxValueBound)) begin
      mval = cac_pkg::CmpW'(cac_pkg::MaxValueBound);
    end else begin
      mval = max_ext;
    end
  end

  always_comb begin
    ctl.calc = (state_q == StSweep) && (cnt_q >= CntCalcLo) && (cnt_q <= CntCalcHi);
    ctl.clr  = accept;
    ctl.seed = first_q;
    ctl.idx  = cac_pkg::IdxW'(cnt_q - CntCalcLo);
    ctl.elem = cac_pkg::CmpW'(elem_q);
    ctl.mval = mval;
  end

  assign ram_re = (state_q == StSweep) && (cnt_q < CntRdEnd);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    first_d     = first_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StSweep;
          cnt_d   = '0;
        end
      end
      StSweep: begin
        cnt_d = cnt_q + cac_pkg::CntW'(1);
        if (cnt_q == CntEnd) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (!last_q) begin
          first_d = 1'b0;
          state_d = StIdle;
        end else if (!out_valid_q || out_ready_i) begin
          first_d     = 1'b1;
          out_valid_d = 1'b1;
          count_d     = acc;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
      max_value_q <= cac_pkg::MaxValueReset;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_value_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    count_q <= count_d;
    if (accept) begin
      elem_q <= elem_value_i;
      last_q <= is_last_i;
    end
  end

  cac_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cnt_q[cac_pkg::IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  cac_cell u_cell (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .rdata_i     (ram_rdata),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .acc_o       (acc)
  );

  assign out_valid_o = out_valid_q;
  assign count_o     = count_q;

`ifndef SYNTH
  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (count_o < cac_pkg::Modulus))
    else $error("count above modulus");

  a_accept_starts_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> ((state_q == StSweep) && (cnt_q == '0)))
    else $error("accepted transaction did not start a sweep");

  a_write_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StSweep) |-> !ram_we)
    else $error("memory write outside a sweep");

  a_result_from_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past((state_q == StFin) && last_q))
    else $error("result without a last element");
`endif

endmodule

>>> verif/tb_constrained_array_count_dp.sv
`timescale 1ns / 1ps

module tb_constrained_array_count_dp;

  localparam int unsigned SweepCycles = cac_pkg::MaxValueBound + 4;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned ReportLimit = 10;
  localparam int unsigned PhaseItems  = 190;
  localparam int unsigned HoldCycles  = 1500;

  logic                       clk_i;
  logic                       rst_ni       = 1'b0;
  logic                       cfg_we_i     = 1'b0;
  logic [7:0]                 cfg_wdata_i  = '0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_ready_o;
  logic [cac_pkg::ElemW-1:0]  elem_value_i = '0;
  logic                       is_last_i    = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i  = 1'b0;
  logic [cac_pkg::CountW-1:0] count_o;

  // predictor state
  logic [cac_pkg::CountW-1:0] way_model [cac_pkg::MaxValueBound] = '{default: '0};
  bit                         fresh_array = 1'b1;
  logic [7:0]                 max_model   = cac_pkg::MaxValueReset;
  logic [cac_pkg::CountW-1:0] pending_counts [$];
  logic [cac_pkg::CountW-1:0] want_count;

  int unsigned mismatches    = 0;
  int unsigned cycles        = 0;
  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;

  constrained_array_count_dp DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .elem_value_i(elem_value_i),
    .is_last_i   (is_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .count_o     (count_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver, with an optional long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_counts.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("count mismatch: expected none, actual %0d", count_o);
      end else begin
        want_count = pending_counts.pop_front();
        if (count_o !== want_count) begin
          mismatches++;
          if (mismatches <= ReportLimit)
            $display("count mismatch: expected %0d, actual %0d", want_count, count_o);
        end
      end
    end
  end

  function automatic logic [cac_pkg::CountW-1:0] mod_add(
      input logic [cac_pkg::CountW-1:0] a,
      input logic [cac_pkg::CountW-1:0] b);
    logic [cac_pkg::CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, cac_pkg::Modulus})
      s = s - {1'b0, cac_pkg::Modulus};
    return s[cac_pkg::CountW-1:0];
  endfunction

  function automatic int unsigned range_top();
    return (max_model > cac_pkg::MaxValueBound) ? cac_pkg::MaxValueBound : max_model;
  endfunction

  // folds one element into the per-value counts, returns 1 when a count is due
  function automatic bit advance_counts(input logic [cac_pkg::ElemW-1:0] v, input bit fin,
                                        output logic [cac_pkg::CountW-1:0] total);
    logic [cac_pkg::CountW-1:0] prior [cac_pkg::MaxValueBound];
    logic [cac_pkg::CountW-1:0] s;
    int unsigned                m;
    m = range_top();
    total = '0;
    if (fresh_array) begin
      for (int i = 0; i < cac_pkg::MaxValueBound; i++)
        way_model[i] = ((v == 0 && i < m) || (v != 0 && v <= m && i == v - 1)) ?
                       cac_pkg::CountW'(1) : '0;
      fresh_array = 1'b0;
    end else begin
      prior = way_model;
      for (int i = 0; i < cac_pkg::MaxValueBound; i++) begin
        s = '0;
        if (i < m && (v == 0 || v == i + 1)) begin
          s = prior[i];
          if (i > 0)
            s = mod_add(s, prior[i-1]);
          if (i + 1 < m)
            s = mod_add(s, prior[i+1]);
        end
        way_model[i] = s;
      end
    end
    if (!fin)
      return 1'b0;
    for (int i = 0; i < m; i++)
      total = mod_add(total, way_model[i]);
    fresh_array = 1'b1;
    return 1'b1;
  endfunction

  function automatic logic [cac_pkg::ElemW-1:0] pick_elem(input int unsigned m);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70)
      return '0;
    if (r < 92)
      return (m > 0) ? cac_pkg::ElemW'($urandom_range(m, 1)) :
                       cac_pkg::ElemW'($urandom_range(cac_pkg::MaxValueBound, 1));
    return cac_pkg::ElemW'($urandom_range(cac_pkg::MaxValueBound, 0));
  endfunction

  function automatic logic [7:0] pick_max();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10)
      return 8'd0;
    if (r < 20)
      return 8'($urandom_range(255, cac_pkg::MaxValueBound + 1));
    if (r < 30)
      return $urandom_range(1) ? 8'd1 : 8'(cac_pkg::MaxValueBound);
    return 8'($urandom_range(cac_pkg::MaxValueBound, 1));
  endfunction

  task automatic send_elem(input logic [cac_pkg::ElemW-1:0] v, input bit fin);
    logic [cac_pkg::CountW-1:0] total;
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    elem_value_i <= v;
    is_last_i    <= fin;
    do @(posedge clk_i); while (!in_ready_o);
    if (advance_counts(v, fin, total))
      pending_counts.push_back(total);
    items_sent++;
  endtask

  // let every pending count out and the sweep in work finish
  task automatic drain();
    @(negedge clk_i) in_valid_i <= 1'b0;
    while (pending_counts.size() != 0)
      @(posedge clk_i);
    repeat (2 * SweepCycles) @(posedge clk_i);
  endtask

  task automatic write_max(input logic [7:0] val);
    drain();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    max_model    = val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic test_single_elements();
    send_elem(8'd0, 1'b1);
    send_elem(8'd1, 1'b1);
    send_elem(8'd100, 1'b1);
    send_elem(8'd101, 1'b1);
    send_elem(8'd128, 1'b1);
    send_elem(8'd0, 1'b0);
    send_elem(8'd0, 1'b1);
  endtask

  task automatic test_max_value_extremes();
    write_max(8'd0);
    send_elem(8'd0, 1'b1);
    send_elem(8'd1, 1'b1);
    write_max(8'd255);
    send_elem(8'd0, 1'b1);
    send_elem(8'd128, 1'b0);
    send_elem(8'd0, 1'b0);
    send_elem(8'd128, 1'b1);
    write_max(8'd1);
    send_elem(8'd0, 1'b0);
    send_elem(8'd0, 1'b0);
    send_elem(8'd1, 1'b1);
    send_elem(8'd1, 1'b0);
    send_elem(8'd2, 1'b1);
  endtask

  task automatic test_reconfig_mid_array();
    write_max(8'd128);
    send_elem(8'd0, 1'b0);
    send_elem(8'd64, 1'b0);
    write_max(8'd50);
    send_elem(8'd0, 1'b0);
    send_elem(8'd0, 1'b1);
  endtask

  // receiver stalls long enough for the block to fill and stall its input
  task automatic test_output_backpressure();
    write_max(8'd128);
    send_idle_pct = 0;
    hold_left     = HoldCycles;
    for (int k = 0; k < 8; k++)
      send_elem(pick_elem(range_top()), 1'b1);
    drain();
  endtask

  task automatic test_random_arrays(input int unsigned sender_pct,
                                    input int unsigned receiver_pct,
                                    input int unsigned n_items);
    int unsigned first_item;
    int unsigned len;
    int unsigned r;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    first_item    = items_sent;
    while (items_sent - first_item < n_items) begin
      if ($urandom_range(7) == 0)
        write_max(pick_max());
      r = $urandom_range(99);
      if (r < 80)
        len = $urandom_range(6, 1);
      else if (r < 95)
        len = $urandom_range(30, 7);
      else
        len = $urandom_range(60, 31);
      for (int k = 0; k < len; k++)
        send_elem(pick_elem(range_top()), k == len - 1);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;
    test_single_elements();
    test_max_value_extremes();
    test_reconfig_mid_array();
    test_output_backpressure();
    test_random_arrays(13, 45, PhaseItems);
    test_random_arrays(45, 13, PhaseItems);
    test_random_arrays(0, 0, PhaseItems);
    drain();
    if (mismatches == 0 && pending_counts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
